>>> hdl/assert_macros.svh
// Assertion macros used by the top level of the priority queue.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle assertion failed");

`endif

>>> hdl/spq_pkg.sv
// Package with the sizes, codes and types of the sorted priority queue.
package spq_pkg;

    localparam int DEPTH      = 16;
    localparam int KEY_WIDTH  = 32;
    localparam int TAG_WIDTH  = 16;
    localparam int OCC_WIDTH  = $clog2(DEPTH + 1);

    typedef logic signed [KEY_WIDTH-1:0] key_t;
    typedef logic [TAG_WIDTH-1:0]        tag_t;
    typedef logic [OCC_WIDTH-1:0]        occ_t;
    typedef logic [1:0]                  op_t;
    typedef logic [1:0]                  status_t;

    localparam op_t OP_ENQ  = 2'd0;
    localparam op_t OP_DEQ  = 2'd1;
    localparam op_t OP_PEEK = 2'd2;

    localparam status_t ST_OK    = 2'd0;
    localparam status_t ST_UNDER = 2'd1;
    localparam status_t ST_OVER  = 2'd2;

    localparam occ_t OCC_FULL = occ_t'(DEPTH);

    // Shift command broadcast to every cell of the chain.
    typedef struct packed {
        logic enq;
        logic deq;
    } cell_ctrl_t;

    // One result beat as held in the output register.
    typedef struct packed {
        key_t    out_key;
        tag_t    out_tag;
        logic    out_valid;
        status_t status;
        occ_t    occupancy;
        logic    is_empty;
        logic    is_full;
    } rsp_item_t;

endpackage

>>> hdl/spq_in_if.sv
// Request channel of the priority queue: opcode, key and tag with valid/ready.
interface spq_in_if;
    import spq_pkg::*;

    logic valid;
    logic ready;
    op_t  opcode;
    key_t item_key;
    tag_t item_tag;

    modport source (output valid, output opcode, output item_key, output item_tag,
                    input ready);
    modport sink (input valid, input opcode, input item_key, input item_tag,
                  output ready);
endinterface

>>> hdl/spq_out_if.sv
// Response channel of the priority queue: head entry and status with valid/ready.
interface spq_out_if;
    import spq_pkg::*;

    logic    valid;
    logic    ready;
    key_t    out_key;
    tag_t    out_tag;
    logic    out_valid;
    status_t status;
    occ_t    occupancy;
    logic    is_empty;
    logic    is_full;

    modport source (output valid, output out_key, output out_tag, output out_valid,
                    output status, output occupancy, output is_empty, output is_full,
                    input ready);
    modport sink (input valid, input out_key, input out_tag, input out_valid,
                  input status, input occupancy, input is_empty, input is_full,
                  output ready);
endinterface

>>> hdl/spq_cell.sv
// One storage cell of the sorted chain: holds an entry and shifts with its neighbours.
module spq_cell (
    input  logic              clk,
    input  spq_pkg::cell_ctrl_t ctrl,
    input  logic              occupied,
    input  spq_pkg::key_t     new_key,
    input  spq_pkg::tag_t     new_tag,
    input  logic              left_go,
    input  spq_pkg::key_t     left_key,
    input  spq_pkg::tag_t     left_tag,
    input  spq_pkg::key_t     right_key,
    input  spq_pkg::tag_t     right_tag,
    output logic              go,
    output spq_pkg::key_t     key,
    output spq_pkg::tag_t     tag
);
    import spq_pkg::*;

    key_t key_reg;
    key_t key_next;
    tag_t tag_reg;
    tag_t tag_next;

    // Strict compare keeps equal keys in arrival order; empty cells always yield.
    assign go = !occupied || (new_key < key_reg);

    always_comb
    begin
        key_next = key_reg;
        tag_next = tag_reg;
        priority if (ctrl.enq && go)
        begin
            key_next = left_go ? left_key : new_key;
            tag_next = left_go ? left_tag : new_tag;
        end
        else if (ctrl.deq)
        begin
            key_next = right_key;
            tag_next = right_tag;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
        tag_reg <= tag_next;
    end

    assign key = key_reg;
    assign tag = tag_reg;

endmodule

>>> hdl/sorted_min_priority_queue.sv
// Top level of the sorted minimum priority queue, a chain of DEPTH entry cells.
// The result beat is registered: it appears in the cycle after its request beat is accepted.
// One operation per cycle while results are taken; all cells compare and shift in the same cycle.
// A request is taken while the output register is empty or being drained.
// Reset clears the entry count and the output valid; cell contents stay unknown
// and are never read before being written.
`include "assert_macros.svh"

module sorted_min_priority_queue (
    input  logic clk,
    input  logic rst_n,
    spq_in_if.sink    req,
    spq_out_if.source rsp
);
    import spq_pkg::*;

    occ_t       count_reg;
    occ_t       count_next;
    logic       rsp_valid_reg;
    rsp_item_t  rsp_reg;
    rsp_item_t  rsp_next;

    logic       accept;
    logic       full;
    logic       empty;
    logic       is_enq;
    logic       is_head;
    cell_ctrl_t ctrl;

    key_t       cell_key [DEPTH];
    tag_t       cell_tag [DEPTH];
    logic       cell_go  [DEPTH];

    // The output register parts the two sides: a new request may enter in the
    // same cycle that the waiting result beat is taken.
    assign req.ready = !rsp_valid_reg || rsp.ready;
    assign accept    = req.valid && req.ready;

    assign full    = (count_reg == OCC_FULL);
    assign empty   = (count_reg == '0);
    assign is_enq  = (req.opcode == OP_ENQ);
    assign is_head = (req.opcode == OP_DEQ) || (req.opcode == OP_PEEK);

    // An overflowing enqueue and an underflowing dequeue leave the chain alone.
    assign ctrl.enq = accept && is_enq && !full;
    assign ctrl.deq = accept && (req.opcode == OP_DEQ) && !empty;

    // Each cell decides locally: the first cell that is empty or whose key exceeds
    // the new one takes the new entry, and every cell after it takes its left neighbour.
    // On dequeue every cell but the last takes its right neighbour; the last keeps its value.
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic occupied;
        logic left_go;
        key_t left_key;
        tag_t left_tag;
        key_t right_key;
        tag_t right_tag;

        assign occupied = (occ_t'(i) < count_reg);

        if (i == 0)
        begin : g_head
            assign left_go  = 1'b0;
            assign left_key = req.item_key;
            assign left_tag = req.item_tag;
        end
        else
        begin : g_body
            assign left_go  = cell_go[i-1];
            assign left_key = cell_key[i-1];
            assign left_tag = cell_tag[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_tail
            // The last cell becomes unoccupied after a dequeue, so it may keep its value.
            assign right_key = cell_key[i];
            assign right_tag = cell_tag[i];
        end
        else
        begin : g_inner
            assign right_key = cell_key[i+1];
            assign right_tag = cell_tag[i+1];
        end

        spq_cell u_cell (
            .clk       (clk),
            .ctrl      (ctrl),
            .occupied  (occupied),
            .new_key   (req.item_key),
            .new_tag   (req.item_tag),
            .left_go   (left_go),
            .left_key  (left_key),
            .left_tag  (left_tag),
            .right_key (right_key),
            .right_tag (right_tag),
            .go        (cell_go[i]),
            .key       (cell_key[i]),
            .tag       (cell_tag[i])
        );
    end

    always_comb
    begin
        count_next = count_reg;
        priority if (ctrl.enq)
        begin
            count_next = count_reg + occ_t'(1);
        end
        else if (ctrl.deq)
        begin
            count_next = count_reg - occ_t'(1);
        end
    end

    // The result reports the head as it stood before the operation and the
    // occupancy as it stands after it.
    always_comb
    begin
        rsp_next.out_key   = '0;
        rsp_next.out_tag   = '0;
        rsp_next.out_valid = 1'b0;
        rsp_next.status    = ST_OK;
        if (is_enq && full)
        begin
            rsp_next.status = ST_OVER;
        end
        else if (is_head && empty)
        begin
            rsp_next.status = ST_UNDER;
        end
        else if (is_head)
        begin
            rsp_next.out_key   = cell_key[0];
            rsp_next.out_tag   = cell_tag[0];
            rsp_next.out_valid = 1'b1;
        end
        rsp_next.occupancy = count_next;
        rsp_next.is_empty  = (count_next == '0);
        rsp_next.is_full   = (count_next == OCC_FULL);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (accept)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp.valid     = rsp_valid_reg;
    assign rsp.out_key   = rsp_reg.out_key;
    assign rsp.out_tag   = rsp_reg.out_tag;
    assign rsp.out_valid = rsp_reg.out_valid;
    assign rsp.status    = rsp_reg.status;
    assign rsp.occupancy = rsp_reg.occupancy;
    assign rsp.is_empty  = rsp_reg.is_empty;
    assign rsp.is_full   = rsp_reg.is_full;

    // The entry count never goes beyond the length of the chain.
    `ASSERT_IMPLIES(a_count_bound, clk, rst_n, 1'b1, count_reg <= OCC_FULL)
    // An accepted enqueue into a queue with room grows the count by one.
    `ASSERT_NEXT(a_enq_grows, clk, rst_n, ctrl.enq, count_reg == $past(count_reg) + occ_t'(1))
    // With two entries or more, the head cell never holds a larger key than its neighbour.
    `ASSERT_IMPLIES(a_head_sorted, clk, rst_n, count_reg >= occ_t'(2), cell_key[0] <= cell_key[1])
    // A beat that carries an entry always reports success.
    `ASSERT_IMPLIES(a_entry_ok, clk, rst_n, rsp_valid_reg && rsp_reg.out_valid,
                    rsp_reg.status == ST_OK)

endmodule

>>> bench/spq_result_checker.sv
`timescale 1ns / 100ps
// Checker that predicts every result beat of the sorted priority queue and compares it.
module spq_result_checker (
    input  logic clk,
    input  logic rst_n,
    spq_in_if    req,
    spq_out_if   rsp,
    output int   errors,
    output int   pending
);
    import spq_pkg::*;

    // Shadow copy of the queue contents, kept in ascending key order.
    key_t      held_keys [DEPTH];
    tag_t      held_tags [DEPTH];
    int        held_count;
    rsp_item_t awaited_results [$];
    rsp_item_t oldest;

    function automatic rsp_item_t apply_request(op_t op, key_t key_in, tag_t tag_in);
        rsp_item_t r;
        int        slot;
        bit        placed;
        r = '0;
        r.status = ST_OK;
        case (op)
            OP_ENQ:
            begin
                if (held_count == DEPTH)
                begin
                    r.status = ST_OVER;
                end
                else
                begin
                    // Strict compare: a new entry lands behind every equal key.
                    slot   = held_count;
                    placed = 1'b0;
                    for (int i = 0; i < held_count; i++)
                    begin
                        if (!placed && key_in < held_keys[i])
                        begin
                            slot   = i;
                            placed = 1'b1;
                        end
                    end
                    for (int i = held_count; i > slot; i--)
                    begin
                        held_keys[i] = held_keys[i-1];
                        held_tags[i] = held_tags[i-1];
                    end
                    held_keys[slot] = key_in;
                    held_tags[slot] = tag_in;
                    held_count++;
                end
            end
            OP_DEQ, OP_PEEK:
            begin
                if (held_count == 0)
                begin
                    r.status = ST_UNDER;
                end
                else
                begin
                    r.out_key   = held_keys[0];
                    r.out_tag   = held_tags[0];
                    r.out_valid = 1'b1;
                    if (op == OP_DEQ)
                    begin
                        for (int i = 1; i < held_count; i++)
                        begin
                            held_keys[i-1] = held_keys[i];
                            held_tags[i-1] = held_tags[i];
                        end
                        held_count--;
                    end
                end
            end
            default:
            begin
            end
        endcase
        r.occupancy = occ_t'(held_count);
        r.is_empty  = (held_count == 0);
        r.is_full   = (held_count == DEPTH);
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_count = 0;
            awaited_results.delete();
            errors  = 0;
            pending = 0;
        end
        else
        begin
            if (req.valid && req.ready)
            begin
                awaited_results.push_back(apply_request(req.opcode, req.item_key,
                                                        req.item_tag));
            end
            if (rsp.valid && rsp.ready)
            begin
                if (awaited_results.size() == 0)
                begin
                    if (errors < 10)
                    begin
                        $display("%0t: result beat with nothing outstanding: key %0d tag %h",
                                 $realtime, rsp.out_key, rsp.out_tag);
                    end
                    errors++;
                end
                else
                begin
                    oldest = awaited_results.pop_front();
                    if (rsp.out_key !== oldest.out_key || rsp.out_tag !== oldest.out_tag ||
                        rsp.out_valid !== oldest.out_valid || rsp.status !== oldest.status ||
                        rsp.occupancy !== oldest.occupancy ||
                        rsp.is_empty !== oldest.is_empty || rsp.is_full !== oldest.is_full)
                    begin
                        if (errors < 10)
                        begin
                            $display("%0t: mismatch, expected key %0d tag %h valid %b st %0d",
                                     $realtime, oldest.out_key, oldest.out_tag,
                                     oldest.out_valid, oldest.status);
                            $display("    occ %0d empty %b full %b; got key %0d tag %h",
                                     oldest.occupancy, oldest.is_empty, oldest.is_full,
                                     rsp.out_key, rsp.out_tag);
                            $display("    valid %b st %0d occ %0d empty %b full %b",
                                     rsp.out_valid, rsp.status, rsp.occupancy,
                                     rsp.is_empty, rsp.is_full);
                        end
                        errors++;
                    end
                end
            end
            pending = awaited_results.size();
        end
    end

endmodule

>>> bench/sorted_min_priority_queue_tb.sv
`timescale 1ns / 100ps
// Top of the priority queue testbench: clock, reset, request stimulus and the verdict.
module sorted_min_priority_queue_tb;
    import spq_pkg::*;

    // The fourth opcode does nothing but still returns a status beat.
    localparam op_t  OP_UNUSED = 2'd3;
    localparam key_t KEY_MAX   = {1'b0, {(KEY_WIDTH-1){1'b1}}};
    localparam key_t KEY_MIN   = {1'b1, {(KEY_WIDTH-1){1'b0}}};

    logic clk;
    logic rst_n;
    int   errors;
    int   pending;

    // Idle percentages of the two sides, and a long hold-off on the response side.
    // The top only changes rx_idle_pct and hold_left at a falling edge, so the
    // response process, which runs on the rising edge, never races with it.
    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    int hold_left   = 0;

    spq_in_if  req_if ();
    spq_out_if rsp_if ();

    sorted_min_priority_queue u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if),
        .rsp   (rsp_if)
    );

    spq_result_checker u_checker (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req_if),
        .rsp     (rsp_if),
        .errors  (errors),
        .pending (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Safety net: far beyond the slowest legal run.
    initial
    begin
        #5_000_000;
        $display("sorted_min_priority_queue_tb failed");
        $finish;
    end

    // Response side. A hold-off, once requested, keeps ready low until its count
    // runs out; otherwise ready is dropped at the current idle rate.
    initial
    begin
        rsp_if.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                rsp_if.ready <= 1'b0;
                hold_left = hold_left - 1;
            end
            else
            begin
                rsp_if.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
            end
        end
    end

    // Keys cluster on a handful of small values in four picks out of ten so that ties
    // are common; the extremes and fully random keys make up the rest.
    function automatic key_t pick_key();
        key_t k;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: k = key_t'(int'($urandom_range(0, 6)) - 3);
            4:
            begin
                case ($urandom_range(0, 3))
                    0:       k = KEY_MIN;
                    1:       k = KEY_MAX;
                    2:       k = KEY_MIN + 1;
                    default: k = KEY_MAX - 1;
                endcase
            end
            default: k = key_t'($urandom);
        endcase
        return k;
    endfunction

    function automatic tag_t pick_tag();
        tag_t t;
        if ($urandom_range(0, 7) == 0)
        begin
            t = ($urandom_range(0, 1) == 0) ? '0 : '1;
        end
        else
        begin
            t = tag_t'($urandom);
        end
        return t;
    endfunction

    // Offers one request beat and returns at the edge that accepts it. Valid is
    // left high, so the caller either offers the next beat in the same step or
    // lowers valid; only one assignment to valid is ever made per step.
    task automatic offer_request(op_t op, key_t k, tag_t t);
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            req_if.valid <= 1'b0;
            @(posedge clk);
        end
        req_if.valid    <= 1'b1;
        req_if.opcode   <= op;
        req_if.item_key <= k;
        req_if.item_tag <= t;
        do
            @(posedge clk);
        while (!req_if.ready);
    endtask

    // Stops offering and waits until the checker has seen every result beat.
    task automatic wait_for_results();
        req_if.valid <= 1'b0;
        do
            @(negedge clk);
        while (pending != 0);
        @(posedge clk);
    endtask

    task automatic set_rates(int tx, int rx);
        req_if.valid <= 1'b0;
        @(negedge clk);
        tx_idle_pct = tx;
        rx_idle_pct = rx;
        @(posedge clk);
    endtask

    // Underflow on an empty queue, the unused opcode, the key extremes and
    // ties at the bottom, middle and top of the key range, then a full drain.
    task automatic run_directed();
        offer_request(OP_DEQ, '0, '0);
        offer_request(OP_PEEK, '1, '1);
        offer_request(OP_UNUSED, KEY_MIN, '0);
        offer_request(OP_ENQ, KEY_MAX, 16'hffff);
        offer_request(OP_ENQ, KEY_MIN, 16'h0000);
        offer_request(OP_ENQ, '0, 16'h0001);
        offer_request(OP_ENQ, '0, 16'h0002);
        offer_request(OP_ENQ, '0, 16'h0003);
        offer_request(OP_ENQ, '1, 16'h0004);
        offer_request(OP_ENQ, KEY_MAX, 16'h0005);
        offer_request(OP_ENQ, KEY_MIN, 16'h0006);
        offer_request(OP_PEEK, KEY_MAX, 16'haaaa);
        offer_request(OP_UNUSED, KEY_MAX, 16'h5555);
        repeat (9)
        begin
            offer_request(OP_DEQ, pick_key(), pick_tag());
        end
    endtask

    // Random traffic in runs: filling runs push the queue to full and beyond,
    // draining runs take it down to underflow, mixed runs sit in between.
    // A sprinkling of the unused opcode rides along in every run.
    task automatic run_random(int count);
        int  sent;
        int  run_len;
        int  flavour;
        int  roll;
        op_t op;
        sent = 0;
        while (sent < count)
        begin
            flavour = $urandom_range(0, 2);
            run_len = $urandom_range(10, 40);
            for (int n = 0; n < run_len && sent < count; n++)
            begin
                roll = $urandom_range(0, 99);
                if (roll < 3)
                begin
                    op = OP_UNUSED;
                end
                else
                begin
                    case (flavour)
                        0:       op = (roll < 85) ? OP_ENQ : ((roll < 95) ? OP_DEQ : OP_PEEK);
                        1:       op = (roll < 18) ? OP_ENQ : ((roll < 88) ? OP_DEQ : OP_PEEK);
                        default: op = (roll < 50) ? OP_ENQ : ((roll < 82) ? OP_DEQ : OP_PEEK);
                    endcase
                end
                offer_request(op, pick_key(), pick_tag());
                sent++;
            end
        end
    endtask

    // Holds the response side off for a long stretch while the request side
    // keeps offering without gaps, so the output register fills and the block
    // has to stall its input until the hold-off ends.
    task automatic hold_and_flood(int count);
        int saved_tx;
        req_if.valid <= 1'b0;
        @(negedge clk);
        saved_tx    = tx_idle_pct;
        tx_idle_pct = 0;
        hold_left   = 150;
        @(posedge clk);
        run_random(count);
        tx_idle_pct = saved_tx;
    endtask

    initial
    begin
        rst_n           = 1'b0;
        req_if.valid    = 1'b0;
        req_if.opcode   = OP_ENQ;
        req_if.item_key = '0;
        req_if.item_tag = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // First phase: the request side idles less than the response side.
        set_rates(28, 57);
        run_directed();
        wait_for_results();
        run_random(120);
        hold_and_flood(30);
        run_random(100);
        // The request side pauses here until every outstanding beat is back.
        wait_for_results();

        // Second phase: the idle rates are swapped.
        set_rates(57, 28);
        run_random(250);
        wait_for_results();

        // Last phase: both sides run flat out.
        set_rates(0, 0);
        run_random(250);

        wait_for_results();
        // Wait on after the last result so that a stray extra beat would still be caught.
        repeat (10) @(posedge clk);
        if (errors == 0 && pending == 0)
        begin
            $display("sorted_min_priority_queue_tb passed");
        end
        else
        begin
            $display("sorted_min_priority_queue_tb failed");
        end
        $finish;
    end

endmodule
